/* hdl/fba_pkg.sv */
package fba_pkg;

    localparam int BLOCKS    = 32;
    localparam int SIZE_BITS = 16;
    localparam int IDX_W     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W     = $clog2(BLOCKS + 1);

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic [0:0] REG_FIT_MODE = 1'b0;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_scan_ctl;

endpackage

/* hdl/fba_table.sv */
module fba_table (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [fba_pkg::IDX_W-1:0]        i_wr_addr,
    input  logic [fba_pkg::SIZE_BITS-1:0]    i_wr_data,
    input  logic [fba_pkg::IDX_W-1:0]        i_rd_addr,
    output logic [fba_pkg::SIZE_BITS-1:0]    o_rd_data
);

    logic [fba_pkg::SIZE_BITS-1:0] r_mem [fba_pkg::BLOCKS];
    logic [fba_pkg::SIZE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/fba_picker.sv */
module fba_picker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fba_pkg::t_scan_ctl               i_ctl,
    input  logic [1:0]                       i_mode,
    input  logic [fba_pkg::SIZE_BITS-1:0]    i_request,
    input  logic [fba_pkg::SIZE_BITS-1:0]    i_room,
    input  logic [fba_pkg::IDX_W-1:0]        i_idx,
    output logic                             o_found,
    output logic [fba_pkg::IDX_W-1:0]        o_pick,
    output logic [fba_pkg::SIZE_BITS-1:0]    o_best
);

    logic                          r_found, n_found;
    logic [fba_pkg::IDX_W-1:0]     r_pick, n_pick;
    logic [fba_pkg::SIZE_BITS-1:0] r_best, n_best;
    logic                          fits;
    logic                          better;

    // One comparator pair serves every entry of the scan.
    assign fits = (i_room >= i_request);

    always_comb begin
        unique case (i_mode)
            fba_pkg::MODE_BEST:  better = (i_room < r_best);
            fba_pkg::MODE_WORST: better = (i_room > r_best);
            default:             better = 1'b0;
        endcase
    end

    always_comb begin
        n_found = r_found;
        n_pick  = r_pick;
        n_best  = r_best;
        if (i_ctl.clear) begin
            n_found = 1'b0;
            n_pick  = '0;
        end else if (i_ctl.valid && fits && (!r_found || better)) begin
            n_found = 1'b1;
            n_pick  = i_idx;
            n_best  = i_room;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_pick  <= '0;
        end else begin
            r_found <= n_found;
            r_pick  <= n_pick;
        end
        r_best <= n_best;
    end

    assign o_found = r_found;
    assign o_pick  = r_pick;
    assign o_best  = r_best;

endmodule

/* hdl/fit_block_allocator_core.sv */
// Channel  Direction  Beat contents
// s_axis   in         tuser: operation [1:0]; tdata: amount [15:0]
// m_axis   out        tuser: granted [0]; tdata: block_index [4:0], zero padded to 8 bits
// apb      in/out     fit_mode at byte address 0
//
// Loads, clears and unknown operations are handled in the idle state.
// An allocate reads the table one entry per cycle from the single read port,
// in the states SCAN, LAST and WRITE; WRITE waits until the output is free.
// An allocate on an empty table skips the scan and goes straight to WRITE.
// Reset is synchronous and empties the table and sets first fit.
// The input is not ready while an allocate is in progress or its result waits to be loaded.
module fit_block_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // amount [15:0]
    input  logic [1:0]  s_axis_tuser,  // operation [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // block_index [4:0], zeros [7:5]
    output logic        m_axis_tuser,  // granted [0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_LAST  = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    logic [1:0]                    r_mode;
    logic [fba_pkg::CNT_W-1:0]     r_loaded, n_loaded;
    logic [fba_pkg::SIZE_BITS-1:0] r_amount, n_amount;
    logic [fba_pkg::IDX_W-1:0]     r_addr, n_addr;
    logic                          r_cmp_valid, n_cmp_valid;
    logic [fba_pkg::IDX_W-1:0]     r_cmp_idx, n_cmp_idx;
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_granted, n_out_granted;
    logic [fba_pkg::IDX_W-1:0]     r_out_idx, n_out_idx;

    logic                          in_accept;
    logic                          out_free;
    logic                          last_addr;
    logic                          wr_en;
    logic [fba_pkg::IDX_W-1:0]     wr_addr;
    logic [fba_pkg::SIZE_BITS-1:0] wr_data;
    logic [fba_pkg::SIZE_BITS-1:0] rd_data;
    fba_pkg::t_scan_ctl            scan_ctl;
    logic                          found;
    logic [fba_pkg::IDX_W-1:0]     pick;
    logic [fba_pkg::SIZE_BITS-1:0] best;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign last_addr     = ({1'b0, r_addr} == (r_loaded - fba_pkg::CNT_W'(1)));

    assign pready = 1'b1;
    assign prdata = (paddr[2] == fba_pkg::REG_FIT_MODE) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= fba_pkg::MODE_FIRST;
        end else if (psel && penable && pwrite && pready && paddr[2] == fba_pkg::REG_FIT_MODE) begin
            r_mode <= pwdata[1:0];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_loaded      = r_loaded;
        n_amount      = r_amount;
        n_addr        = r_addr;
        n_cmp_valid   = 1'b0;
        n_cmp_idx     = r_addr;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_granted = r_out_granted;
        n_out_idx     = r_out_idx;
        scan_ctl      = '{clear: 1'b0, valid: r_cmp_valid};
        wr_en         = 1'b0;
        wr_addr       = pick;
        wr_data       = best - r_amount;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_amount = s_axis_tdata[fba_pkg::SIZE_BITS-1:0];
                    unique case (s_axis_tuser)
                        fba_pkg::OP_LOAD: begin
                            if (r_loaded < fba_pkg::CNT_W'(fba_pkg::BLOCKS)) begin
                                wr_en    = 1'b1;
                                wr_addr  = r_loaded[fba_pkg::IDX_W-1:0];
                                wr_data  = s_axis_tdata[fba_pkg::SIZE_BITS-1:0];
                                n_loaded = r_loaded + fba_pkg::CNT_W'(1);
                            end
                        end
                        fba_pkg::OP_CLEAR: begin
                            n_loaded = '0;
                        end
                        fba_pkg::OP_ALLOC: begin
                            scan_ctl.clear = 1'b1;
                            n_addr         = '0;
                            n_state        = (r_loaded == '0) ? S_WRITE : S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_cmp_valid = 1'b1;
                n_cmp_idx   = r_addr;
                if (last_addr) begin
                    n_state = S_LAST;
                end else begin
                    n_addr = r_addr + fba_pkg::IDX_W'(1);
                end
            end
            S_LAST: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (out_free) begin
                    wr_en         = found;
                    n_out_valid   = 1'b1;
                    n_out_granted = found;
                    n_out_idx     = found ? pick : '0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loaded    <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
        r_amount      <= n_amount;
        r_addr        <= n_addr;
        r_cmp_idx     <= n_cmp_idx;
        r_out_granted <= n_out_granted;
        r_out_idx     <= n_out_idx;
    end

    fba_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    fba_picker u_picker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_mode    (r_mode),
        .i_request (r_amount),
        .i_room    (rd_data),
        .i_idx     (r_cmp_idx),
        .o_found   (found),
        .o_pick    (pick),
        .o_best    (best)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_granted;
    assign m_axis_tdata  = {{(8 - fba_pkg::IDX_W){1'b0}}, r_out_idx};

`ifndef NO_ASSERTIONS
    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= fba_pkg::CNT_W'(fba_pkg::BLOCKS))
        else $error("Block count exceeds the table size.");

    a_denied_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0)
        else $error("A denied result carries a nonzero block index.");

    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && s_axis_tuser == fba_pkg::OP_ALLOC |=> !s_axis_tready)
        else $error("Input ready right after an allocate was taken.");

    a_writeback_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE && wr_en |-> found)
        else $error("Write back without a chosen block.");
`endif

endmodule
